@@ src/catmull_rom_path_tessellator_top_assert.svh @@
// assertion macros for the catmull-rom tessellator checker
`ifndef CATMULL_ROM_PATH_TESSELLATOR_TOP_ASSERT_SVH
`define CATMULL_ROM_PATH_TESSELLATOR_TOP_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define CRPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define CRPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequence holds in the cycle after reset is seen
`define CRPT_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

@@ src/crpt_pkg.sv @@
// shared types, constants and weight helper for the catmull-rom tessellator
package crpt_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int COLOR_WIDTH    = 32;
   localparam int STEPS_DEFAULT  = 20;
   localparam int WEIGHT_FRAC    = 15;
   localparam int WEIGHT_WIDTH   = WEIGHT_FRAC + 2;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COLOR_WIDTH-1:0]        color_type;

   // register indexes of the control port
   typedef enum logic {
      REG_HL_ENABLE = 1'b0,
      REG_HL_COLOR  = 1'b1
   } reg_index_type;

   localparam color_type HL_COLOR_RESET = 32'hFFFF00FF;

   // input word: one control point
   typedef struct packed {
      coord_type in_x;
      coord_type in_y;
      color_type point_color;
      logic      route_end;
   } req_word_type;

   // output word: one curve vertex
   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      color_type out_color;
      logic      run_last;
   } rsp_word_type;

   // one segment to tessellate: p0..p3, colour, and whether its end vertex closes the word
   typedef struct packed {
      coord_type [3:0] px;
      coord_type [3:0] py;
      color_type       color;
      logic            last;
   } seg_type;

   // basis numerators over 2*s^3 for sample i of s
   function automatic longint cr_numerator(longint s, longint i, int k);
      longint n;
      case (k)
         0:       n = -i * s * s + 2 * i * i * s - i * i * i;
         1:       n = 2 * s * s * s - 5 * i * i * s + 3 * i * i * i;
         2:       n = i * s * s + 4 * i * i * s - 3 * i * i * i;
         3:       n = -i * i * s + i * i * i;
         default: n = 0;
      endcase
      return n;
   endfunction

endpackage

@@ src/crpt_front.sv @@
// front end: point window, segment classification and segment push
module crpt_front
   import crpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   input  logic         hl_enable,
   input  color_type    hl_color,
   output logic         push_en,
   output seg_type      push_data,
   input  logic         q_full
);

   coord_type win_x_ff [3];
   coord_type win_y_ff [3];
   color_type win_c_ff [3];
   coord_type win_x_in [3];
   coord_type win_y_in [3];
   color_type win_c_in [3];
   logic [1:0] held_ff, held_in;
   logic       pend_valid_ff, pend_valid_in;
   seg_type    pend_seg_ff, pend_seg_in;

   logic      accept;
   logic      has_a, has_b;
   seg_type   seg_a, seg_b;
   coord_type nx, ny;
   logic      last;

   assign nx        = req_data.in_x;
   assign ny        = req_data.in_y;
   assign last      = req_data.route_end;
   assign req_ready = !pend_valid_ff && !q_full;
   assign accept    = req_valid && req_ready;

   // segments closed by the incoming point
   always_comb begin
      has_a = 1'b0;
      has_b = 1'b0;
      seg_a = '0;
      seg_b = '0;
      case (held_ff)
         2'd1: begin
            has_a       = last;
            seg_a.px    = {nx, nx, win_x_ff[0], win_x_ff[0]};
            seg_a.py    = {ny, ny, win_y_ff[0], win_y_ff[0]};
            seg_a.color = hl_enable ? hl_color : win_c_ff[0];
            seg_a.last  = 1'b1;
         end
         2'd2: begin
            has_a       = 1'b1;
            seg_a.px    = {nx, win_x_ff[1], win_x_ff[0], win_x_ff[0]};
            seg_a.py    = {ny, win_y_ff[1], win_y_ff[0], win_y_ff[0]};
            seg_a.color = hl_enable ? hl_color : win_c_ff[0];
            seg_a.last  = !last;
            has_b       = last;
            seg_b.px    = {nx, nx, win_x_ff[1], win_x_ff[0]};
            seg_b.py    = {ny, ny, win_y_ff[1], win_y_ff[0]};
            seg_b.color = hl_enable ? hl_color : win_c_ff[1];
            seg_b.last  = 1'b1;
         end
         2'd3: begin
            has_a       = 1'b1;
            seg_a.px    = {nx, win_x_ff[2], win_x_ff[1], win_x_ff[0]};
            seg_a.py    = {ny, win_y_ff[2], win_y_ff[1], win_y_ff[0]};
            seg_a.color = hl_enable ? hl_color : win_c_ff[1];
            seg_a.last  = !last;
            has_b       = last;
            seg_b.px    = {nx, nx, win_x_ff[2], win_x_ff[1]};
            seg_b.py    = {ny, ny, win_y_ff[2], win_y_ff[1]};
            seg_b.color = hl_enable ? hl_color : win_c_ff[2];
            seg_b.last  = 1'b1;
         end
         default: begin
            has_a = 1'b0;
         end
      endcase
   end

   // push pending second segment first, else the first segment of a new word
   assign push_en   = !q_full && (pend_valid_ff || (accept && has_a));
   assign push_data = pend_valid_ff ? pend_seg_ff : seg_a;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_seg_in   = pend_seg_ff;
      if (pend_valid_ff) begin
         if (!q_full) begin
            pend_valid_in = 1'b0;
         end
      end else if (accept && has_b) begin
         pend_valid_in = 1'b1;
         pend_seg_in   = seg_b;
      end
   end

   // window update and held count
   always_comb begin
      win_x_in = win_x_ff;
      win_y_in = win_y_ff;
      win_c_in = win_c_ff;
      held_in  = held_ff;
      if (accept) begin
         if (held_ff == 2'd3) begin
            win_x_in[0] = win_x_ff[1];
            win_y_in[0] = win_y_ff[1];
            win_c_in[0] = win_c_ff[1];
            win_x_in[1] = win_x_ff[2];
            win_y_in[1] = win_y_ff[2];
            win_c_in[1] = win_c_ff[2];
            win_x_in[2] = nx;
            win_y_in[2] = ny;
            win_c_in[2] = req_data.point_color;
         end else begin
            win_x_in[held_ff] = nx;
            win_y_in[held_ff] = ny;
            win_c_in[held_ff] = req_data.point_color;
         end
         if (last) begin
            held_in = 2'd0;
         end else if (held_ff != 2'd3) begin
            held_in = held_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 2'd0;
         pend_valid_ff <= 1'b0;
      end else begin
         held_ff       <= held_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_seg_ff <= pend_seg_in;
      win_x_ff    <= win_x_in;
      win_y_ff    <= win_y_in;
      win_c_ff    <= win_c_in;
   end

endmodule

@@ src/crpt_queue.sv @@
// short segment queue between front and back
module crpt_queue
   import crpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_en,
   input  seg_type push_data,
   output logic    full,
   input  logic    pop_en,
   output seg_type head,
   output logic    empty
);

   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

   seg_type         entry_ff [QUEUE_DEPTH];
   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         count_in = count_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/crpt_back.sv @@
// back end: step sequencer, basis multiply, round and saturate, output register
module crpt_back
   import crpt_pkg::*;
#(
   parameter int STEPS = STEPS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  seg_type      head,
   input  logic         empty,
   output logic         pop_en,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int StepW = $clog2(STEPS + 1);
   localparam int ProdW = WEIGHT_WIDTH + COORD_WIDTH;
   localparam int SumW  = ProdW + 2;
   localparam logic signed [SumW-1:0] Half  = SumW'(longint'(1) << (WEIGHT_FRAC - 1));
   localparam logic signed [SumW-1:0] SatHi = SumW'((longint'(1) << (COORD_WIDTH - 1)) - 1);
   localparam logic signed [SumW-1:0] SatLo = ~SatHi;

   // basis weight table, one row per step, Q1.15 rounded half up
   logic signed [WEIGHT_WIDTH-1:0] w_tab [STEPS+1][4];

   for (genvar g = 0; g <= STEPS; g++) begin : g_row
      for (genvar k = 0; k < 4; k++) begin : g_col
         localparam longint Den   = 2 * longint'(STEPS) * STEPS * STEPS;
         localparam longint Num   = cr_numerator(longint'(STEPS), longint'(g), k);
         localparam longint Numer = 2 * Num * (longint'(1) << WEIGHT_FRAC) + Den;
         localparam longint Div   = 2 * Den;
         localparam longint Wt    = (Numer >= 0) ? Numer / Div
                                                 : -((Div - 1 - Numer) / Div);
         assign w_tab[g][k] = WEIGHT_WIDTH'(Wt);
      end
   end

   logic adv, issue, seg_done;
   logic [StepW-1:0] step_ff, step_in;

   // stage 1: weights and points
   logic                           s1_valid_ff;
   logic signed [WEIGHT_WIDTH-1:0] s1_w_ff [4];
   coord_type                      s1_px_ff [4];
   coord_type                      s1_py_ff [4];
   logic                           s1_end_ff;
   logic                           s1_last_ff;
   color_type                      s1_color_ff;

   // stage 2: products
   logic                    s2_valid_ff;
   logic signed [ProdW-1:0] s2_prodx_ff [4];
   logic signed [ProdW-1:0] s2_prody_ff [4];
   logic signed [ProdW-1:0] s2_prodx_in [4];
   logic signed [ProdW-1:0] s2_prody_in [4];
   coord_type               s2_ex_ff, s2_ey_ff;
   logic                    s2_end_ff;
   logic                    s2_last_ff;
   color_type               s2_color_ff;

   // output register
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff, rsp_data_in;

   logic signed [SumW-1:0] accx, accy, shx, shy;
   coord_type              satx, saty;

   // whole back pipeline moves when the output register can take a word
   assign adv      = !rsp_valid_ff || rsp_ready;
   assign issue    = adv && !empty;
   assign seg_done = (step_ff == StepW'(STEPS));
   assign pop_en   = issue && seg_done;
   assign step_in  = issue ? (seg_done ? '0 : step_ff + 1'b1) : step_ff;

   // basis multiplies
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s2_prodx_in[k] = s1_w_ff[k] * s1_px_ff[k];
         s2_prody_in[k] = s1_w_ff[k] * s1_py_ff[k];
      end
   end

   // sum, round half up, saturate
   always_comb begin
      accx = Half;
      accy = Half;
      for (int k = 0; k < 4; k++) begin
         accx = accx + SumW'(s2_prodx_ff[k]);
         accy = accy + SumW'(s2_prody_ff[k]);
      end
      shx = accx >>> WEIGHT_FRAC;
      shy = accy >>> WEIGHT_FRAC;
      if (shx > SatHi) begin
         satx = COORD_WIDTH'(SatHi);
      end else if (shx < SatLo) begin
         satx = COORD_WIDTH'(SatLo);
      end else begin
         satx = COORD_WIDTH'(shx);
      end
      if (shy > SatHi) begin
         saty = COORD_WIDTH'(SatHi);
      end else if (shy < SatLo) begin
         saty = COORD_WIDTH'(SatLo);
      end else begin
         saty = COORD_WIDTH'(shy);
      end
      rsp_data_in.out_x     = s2_end_ff ? s2_ex_ff : satx;
      rsp_data_in.out_y     = s2_end_ff ? s2_ey_ff : saty;
      rsp_data_in.out_color = s2_color_ff;
      rsp_data_in.run_last  = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (adv) begin
            s1_valid_ff  <= !empty;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            s1_w_ff[k]     <= w_tab[step_ff][k];
            s1_px_ff[k]    <= head.px[k];
            s1_py_ff[k]    <= head.py[k];
            s2_prodx_ff[k] <= s2_prodx_in[k];
            s2_prody_ff[k] <= s2_prody_in[k];
         end
         s1_end_ff   <= seg_done;
         s1_last_ff  <= head.last && seg_done;
         s1_color_ff <= head.color;
         s2_ex_ff    <= s1_px_ff[2];
         s2_ey_ff    <= s1_py_ff[2];
         s2_end_ff   <= s1_end_ff;
         s2_last_ff  <= s1_last_ff;
         s2_color_ff <= s1_color_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/catmull_rom_path_tessellator_top.sv @@
// top level of the catmull-rom route tessellator
//
//   channel   dir   handshake              word
//   req       in    req_valid/req_ready    control point (req_word_type)
//   rsp       out   rsp_valid/rsp_ready    curve vertex (rsp_word_type)
//   control   in    psel/penable, pready   highlight_enable at 0, highlight_color at 4
//
// each point yields 0, STEPS+1 or 2*(STEPS+1) vertex words, one per cycle while
// rsp_ready is held high; the back end step sequencer issues one sample per cycle
// while the output register can take a word and the segment queue is not empty.
// a point's segment passes the segment queue, stage 1, stage 2 and the output register.
// reset clears the held point count, queue pointers and pipeline valid bits.
// a stall on rsp freezes the back end; the front keeps taking points until
// the two-entry segment queue fills, and pauses while a second segment waits.
module catmull_rom_path_tessellator_top
   import crpt_pkg::*;
#(
   parameter int STEPS = STEPS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_word_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_word_type              rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic          hl_enable_ff;
   color_type     hl_color_ff;
   logic          csr_write;
   reg_index_type csr_index;

   logic    push_en, q_full, pop_en, q_empty;
   seg_type push_data, q_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hl_enable_ff <= 1'b0;
         hl_color_ff  <= HL_COLOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_HL_ENABLE: hl_enable_ff <= pwdata[0];
            REG_HL_COLOR:  hl_color_ff  <= pwdata[COLOR_WIDTH-1:0];
            default:       hl_enable_ff <= hl_enable_ff;
         endcase
      end
   end

   // register read
   always_comb begin
      case (csr_index)
         REG_HL_ENABLE: prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, hl_enable_ff};
         REG_HL_COLOR:  prdata = CSR_DATA_WIDTH'(hl_color_ff);
         default:       prdata = '0;
      endcase
   end

   crpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .hl_enable (hl_enable_ff),
      .hl_color  (hl_color_ff),
      .push_en   (push_en),
      .push_data (push_data),
      .q_full    (q_full)
   );

   crpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (push_data),
      .full      (q_full),
      .pop_en    (pop_en),
      .head      (q_head),
      .empty     (q_empty)
   );

   crpt_back #(
      .STEPS (STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop_en    (pop_en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/crpt_checker.sv @@
// port-level checker for the catmull-rom tessellator and its bind
`include "catmull_rom_path_tessellator_top_assert.svh"

module crpt_checker
   import crpt_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rsp_word_type              rsp_data,
   input logic                      psel,
   input logic                      pwrite,
   input logic [CSR_ADDR_WIDTH-1:0] paddr,
   input logic [CSR_DATA_WIDTH-1:0] prdata
);

   // a stalled vertex word stays offered
   `CRPT_ASSERT_NEXT(a_rsp_valid_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped while stalled")

   // a stalled vertex word keeps its payload
   `CRPT_ASSERT_NEXT(a_rsp_data_hold, clock, reset,
      rsp_valid && !rsp_ready, $stable(rsp_data), "rsp_data changed while stalled")

   // after reset the block is empty and ready for a point
   `CRPT_ASSERT_AFTER_RESET(a_reset_idle, clock, reset,
      !rsp_valid && req_ready, "block not idle after reset")

   // the enable register reads back as a single bit
   `CRPT_ASSERT_NOW(a_enable_read, clock, reset,
      psel && !pwrite && (paddr[CSR_ADDR_WIDTH-1:2] == 1'b0),
      prdata[CSR_DATA_WIDTH-1:1] == '0, "enable register read has upper bits set")

endmodule

bind catmull_rom_path_tessellator_top crpt_checker u_checker (.*);
